// ----- rtl/core/alft_pkg.sv -----
package alft_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h9D;
  localparam logic [7:0] HDR_MARK  = 8'h80;
  localparam logic [7:0] CTL_BOT   = 8'o50;
  localparam logic [7:0] CTL_BOTM  = 8'o51;
  localparam logic [7:0] CTL_BOTS  = 8'o52;
  localparam logic [15:0] CRC_POLY_RESET = 16'hA001;

  // op queue between front and back
  localparam int OPQ_AW = 2;
  localparam int OPQ_DEPTH = 1 << OPQ_AW;

  typedef struct packed {
    logic        command;
    logic [15:0] channel;
    logic [7:0]  payload_byte;
    logic [7:0]  control_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       last_of_run;
  } out_word_t;

  // one classified item: what the back end has to carry out
  typedef struct packed {
    logic        chg;         // channel changed, close an open frame first
    logic [15:0] channel;
    logic [1:0]  nbytes;      // bytes to put: 0, 1 or 2
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        post_close;  // close after the last byte
  } op_t;

  function automatic logic [15:0] crc_entry(input logic [15:0] poly, input logic [7:0] idx);
    logic [15:0] r;
    r = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] poly, input logic [15:0] crc,
                                             input logic [7:0] b);
    return crc_entry(poly, crc[7:0] ^ b) ^ {8'h00, crc[15:8]};
  endfunction

endpackage

// ----- rtl/core/alft_front.sv -----
module alft_front import alft_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_word_t item,
  output logic     full,
  input  logic     q_full,
  output logic     q_push,
  output op_t      q_op
);

  logic [15:0] cur_ch;
  logic        ch_valid;
  logic        accept;
  logic        drop;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    q_op = '0;
    q_op.chg = !ch_valid || (item.channel != cur_ch);
    q_op.channel = item.channel;
    if (!item.command) begin
      q_op.b0 = item.payload_byte;
      q_op.nbytes = (item.payload_byte == ESC_BYTE) ? 2'd2 : 2'd1;
    end else if (item.control_byte != 8'h00) begin
      q_op.b0 = ESC_BYTE;
      q_op.b1 = item.control_byte;
      q_op.nbytes = 2'd2;
      q_op.post_close = !(item.control_byte inside {CTL_BOT, CTL_BOTM, CTL_BOTS});
    end
    // an empty end of message on the same channel has no effect at all
    drop = (q_op.nbytes == 2'd0) && !q_op.chg;
    q_push = accept && !drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch   <= '0;
      ch_valid <= 1'b0;
    end else if (accept) begin
      cur_ch   <= item.channel;
      ch_valid <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/alft_opq.sv -----
module alft_opq import alft_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  op_t  wr_op,
  output logic q_full,
  input  logic rd,
  output op_t  rd_op,
  output logic rd_valid
);

  op_t               mem [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr;
  logic [OPQ_AW-1:0] rd_ptr;
  logic [OPQ_AW:0]   count;

  assign q_full   = (count == (OPQ_AW+1)'(OPQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/alft_back.sv -----
module alft_back import alft_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  op_t         op,
  input  logic        op_valid,
  output logic        op_pop,
  output out_word_t   result,
  output logic        empty,
  input  logic        pop
);

  localparam int CW = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_FRAME - 4);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_H1    = 4'd1;
  localparam logic [3:0] S_H2    = 4'd2;
  localparam logic [3:0] S_BYTE  = 4'd3;
  localparam logic [3:0] S_STUFF = 4'd4;
  localparam logic [3:0] S_CLO   = 4'd5;
  localparam logic [3:0] S_CLO_S = 4'd6;
  localparam logic [3:0] S_CHI   = 4'd7;
  localparam logic [3:0] S_CHI_S = 4'd8;
  localparam logic [3:0] S_F1    = 4'd9;
  localparam logic [3:0] S_F2    = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next, count_plus;
  logic [1:0]    pos, pos_next, pos_plus;
  logic [15:0]   crc, crc_next;
  logic [15:0]   crc_poly;
  logic [15:0]   seed;
  op_t           cur;
  logic          out_valid;
  logic          out_free, adv, emit, fend;
  logic [7:0]    cur_byte, hdr1, hdr2, byte_out;
  logic [3:0]    put_start;

  function automatic logic [3:0] after_put(input logic [CW-1:0] cnt, input logic [1:0] p,
                                           input op_t o);
    if (cnt == LIMIT) begin
      return S_CLO;
    end else if (p < o.nbytes) begin
      return S_BYTE;
    end else if (o.post_close) begin
      return S_CLO;
    end
    return S_IDLE;
  endfunction

  assign empty = !out_valid;

  always_comb begin
    out_free   = !out_valid || pop;
    adv        = (state == S_IDLE) || out_free;
    emit       = (state != S_IDLE) && out_free;
    cur_byte   = pos[0] ? cur.b1 : cur.b0;
    hdr1       = HDR_MARK | {1'b0, cur.channel[11:6], 1'b0};
    hdr2       = HDR_MARK | {1'b0, cur.channel[5:0], 1'b0};
    put_start  = (count == '0) ? S_H1 : S_BYTE;
    count_plus = count + 1'b1;
    pos_plus   = pos + 1'b1;

    state_next = state;
    count_next = count;
    pos_next   = pos;
    crc_next   = crc;
    byte_out   = 8'h00;
    fend       = 1'b0;
    op_pop     = 1'b0;

    case (state)
      S_IDLE: begin
        if (op_valid) begin
          op_pop   = 1'b1;
          pos_next = 2'd0;
          if (op.chg && (count != '0)) begin
            state_next = S_CLO;
          end else if (op.nbytes != 2'd0) begin
            state_next = put_start;
          end
        end
      end
      S_H1: begin
        byte_out   = hdr1;
        crc_next   = crc_update(crc_poly, seed, hdr1);
        state_next = S_H2;
      end
      S_H2: begin
        byte_out   = hdr2;
        crc_next   = crc_update(crc_poly, crc, hdr2);
        state_next = S_BYTE;
      end
      S_BYTE: begin
        byte_out   = cur_byte;
        crc_next   = crc_update(crc_poly, crc, cur_byte);
        count_next = count_plus;
        pos_next   = pos_plus;
        state_next = (cur_byte == FLAG_BYTE) ? S_STUFF : after_put(count_plus, pos_plus, cur);
      end
      S_STUFF: begin
        state_next = after_put(count, pos, cur);
      end
      S_CLO: begin
        byte_out   = crc[7:0];
        state_next = (crc[7:0] == FLAG_BYTE) ? S_CLO_S : S_CHI;
      end
      S_CLO_S: begin
        state_next = S_CHI;
      end
      S_CHI: begin
        byte_out   = crc[15:8];
        state_next = (crc[15:8] == FLAG_BYTE) ? S_CHI_S : S_F1;
      end
      S_CHI_S: begin
        state_next = S_F1;
      end
      S_F1: begin
        byte_out   = FLAG_BYTE;
        state_next = S_F2;
      end
      S_F2: begin
        byte_out   = FLAG_BYTE;
        fend       = 1'b1;
        count_next = '0;
        state_next = (pos < cur.nbytes) ? S_H1 : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    seed <= crc_entry(crc_poly, 8'hFF);
    if (op_pop) begin
      cur <= op;
    end
    if (emit) begin
      result.line_byte   <= byte_out;
      result.frame_end   <= fend;
      result.last_of_run <= (state_next == S_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      crc       <= '0;
      crc_poly  <= CRC_POLY_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        crc_poly <= cfg_data;
      end
      if (adv) begin
        state <= state_next;
        count <= count_next;
        pos   <= pos_next;
        crc   <= crc_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/async_link_frame_transmitter_top.sv -----
// Framed serial-line transmitter.
// Input channel: push/full queue of message words (payload byte or end of
//   message with control byte, plus channel number). A word is taken when
//   push is high and full is low.
// Output channel: empty/pop queue of line bytes; the head word sits on
//   result while empty is low and leaves when pop is high.
// cfg_write/cfg_data load the reflected CRC-16 polynomial (reset 0xA001);
//   write it only while the block is idle.
// When the back end is idle, a taken word passes the op queue, the dispatch
//   state and the byte register before its first byte is on result.
// Throughput: the back end sends one line byte per cycle while pop keeps up,
//   and returns to its dispatch state between words; headers, escapes,
//   stuffing and frame closes each add an extra line byte.
// The front end keeps taking words into a 4-entry op queue while the back
//   end works or the receiver stalls; full rises only when that queue fills.
// Stalls on pop hold the byte sequencer in place; nothing is dropped.
// Reset (synchronous, rst high) empties both queues, closes no frame,
//   forgets the channel and restores the polynomial.
module async_link_frame_transmitter_top import alft_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_word_t    item,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_word_t   result,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  op_t  head_op;
  logic head_valid;

  // classify words, track the channel
  alft_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_op)
  );

  // decouples word intake from byte output
  alft_opq u_opq (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_op    (q_op),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_op    (head_op),
    .rd_valid (head_valid)
  );

  // byte sequencer, CRC and output register
  alft_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .op        (head_op),
    .op_valid  (head_valid),
    .op_pop    (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

`ifndef SYNTHESIS
  // closing flag word always carries the flag value
  a_fend_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> (result.line_byte == FLAG_BYTE))
    else $error("frame_end on a non-flag byte");

  // an op with nothing to put only exists to close on a channel change
  a_op_useful: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (head_op.nbytes == 2'd0)) |-> head_op.chg)
    else $error("useless op reached the back end");

  // the back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> head_valid)
    else $error("op queue underflow");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

// ----- tb/sv/async_link_frame_transmitter_top_tb.sv -----
`timescale 1ns / 100ps

module async_link_frame_transmitter_top_tb import alft_pkg::*; ();

  // Frame length used for the DUT; the counted-byte limit is FRAME_LEN - 4.
  localparam int FRAME_LEN = 256;
  localparam int FULL_COUNT = FRAME_LEN - 4;
  // Word codes for the command bit of an input word.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END = 1'b1;
  // Extra drain wait to cover the pipeline (dispatch, byte register), with margin.
  localparam int DRAIN_PAD = 8;
  // Cycles with no word moving on either side before we give up.
  localparam int STALL_LIMIT = 2000;
  // Rough size of each random phase, in input words.
  localparam int PHASE_WORDS = 115;

  // How a frame-filling run ends right at the full-frame boundary.
  typedef enum {
    SPLIT_AT_ESCAPE,     // 0x9D payload lands on the last slot, its escape opens a new frame
    SPLIT_AT_CONTROL,    // 0x9D of a control lands on the last slot, control opens a new frame
    CONTROL_AFTER_FULL   // closing control fills the frame itself, no second close
  } fill_end_e;

  // One row of the directed table. When typed is set, the expected line
  // bytes are given in the row (first byte in [31:24]); otherwise the
  // predictor supplies them.
  typedef struct packed {
    in_word_t    w;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] bytes;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  in_word_t    item = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   result;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  async_link_frame_transmitter_top #(
    .MAX_FRAME(FRAME_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Framer model: our own copy of polynomial, channel and frame state.
  // ---------------------------------------------------------------
  logic [15:0] poly_q;
  logic [15:0] chan_q;
  logic        chan_seen;
  int          fill_cnt;
  logic [15:0] crc_q;

  out_word_t   step_words[$];     // line bytes caused by the current word
  out_word_t   line_bytes_due[$]; // line bytes still owed by the DUT

  int          mismatch_cnt = 0;
  int          words_sent = 0;
  logic [15:0] last_chan = '0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  int          rx_hold = 0;
  int          rx_roll;
  int          idle_cycles = 0;
  dir_row_t    dir_tab[$];

  // Byte table entry of the reflected CRC for the current polynomial.
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] r;
    r = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ poly_q;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    return crc_tab(crc[7:0] ^ b) ^ {8'h00, crc[15:8]};
  endfunction

  task automatic put_line(input logic [7:0] b, input logic fend);
    out_word_t o;
    o.line_byte = b;
    o.frame_end = fend;
    o.last_of_run = 1'b0;
    step_words.push_back(o);
  endtask

  // CRC low byte then high byte, each stuffed after a flag, then two flags.
  task automatic close_open_frame();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = crc_q[7:0];
    hi = crc_q[15:8];
    if (fill_cnt != 0) begin
      put_line(lo, 1'b0);
      if (lo == FLAG_BYTE) put_line(8'h00, 1'b0);
      put_line(hi, 1'b0);
      if (hi == FLAG_BYTE) put_line(8'h00, 1'b0);
      fill_cnt = 0;
      put_line(FLAG_BYTE, 1'b0);
      put_line(FLAG_BYTE, 1'b1);
    end
  endtask

  // One counted frame byte, opening the frame with its header if needed.
  task automatic frame_byte(input logic [7:0] c);
    logic [15:0] t;
    logic [7:0]  hdr;
    if (fill_cnt == 0) begin
      t = (chan_q >> 5) & 16'h007E;
      hdr = HDR_MARK | t[7:0];
      put_line(hdr, 1'b0);
      crc_q = crc_fold(crc_tab(8'hFF), hdr);
      t = (chan_q << 1) & 16'h007E;
      hdr = HDR_MARK | t[7:0];
      put_line(hdr, 1'b0);
      crc_q = crc_fold(crc_q, hdr);
    end
    put_line(c, 1'b0);
    // stuffed zero after a flag is neither counted nor fed to the CRC
    if (c == FLAG_BYTE) put_line(8'h00, 1'b0);
    crc_q = crc_fold(crc_q, c);
    fill_cnt++;
    if (fill_cnt >= FULL_COUNT) close_open_frame();
  endtask

  // Works out every line byte one accepted input word causes.
  task automatic encode_word(input in_word_t w);
    step_words.delete();
    if ((!chan_seen || w.channel != chan_q) && fill_cnt > 0) close_open_frame();
    chan_q = w.channel;
    chan_seen = 1'b1;
    if (w.command == CMD_DATA) begin
      frame_byte(w.payload_byte);
      // escape zero after 0x9D is a real, counted frame byte
      if (w.payload_byte == ESC_BYTE) frame_byte(8'h00);
    end else if (w.control_byte != 8'h00) begin
      frame_byte(ESC_BYTE);
      frame_byte(w.control_byte);
      if (w.control_byte != CTL_BOT && w.control_byte != CTL_BOTM &&
          w.control_byte != CTL_BOTS) begin
        close_open_frame();
      end
    end
    if (step_words.size() > 0) step_words[$].last_of_run = 1'b1;
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one; calm
  // stretches run with no gaps at all.
  function automatic int tx_gap();
    int r;
    if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
    r = $urandom_range(0, 99);
    if (calm_tx || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word, waits for it to be taken, then queues what it owes.
  // A gap of zero leaves push high so the next word follows directly.
  task automatic send_word(input in_word_t w, input logic typed, input int n,
                           input logic [31:0] bytes);
    out_word_t o;
    int        gap;
    item <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    encode_word(w);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        o.line_byte = bytes[31 - 8 * i -: 8];
        o.frame_end = 1'b0;
        o.last_of_run = (i == n - 1);
        line_bytes_due.push_back(o);
      end
    end else begin
      foreach (step_words[i]) line_bytes_due.push_back(step_words[i]);
    end
    words_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic cmd, input logic [15:0] ch, input logic [7:0] pb,
                           input logic [7:0] ctl);
    in_word_t w;
    w.command = cmd;
    w.channel = ch;
    w.payload_byte = pb;
    w.control_byte = ctl;
    send_word(w, 1'b0, 0, 32'h0);
  endtask

  task automatic add_row(input logic cmd, input logic [15:0] ch, input logic [7:0] pb,
                         input logic [7:0] ctl, input logic typed, input int n,
                         input logic [31:0] bytes);
    dir_row_t r;
    r.w.command = cmd;
    r.w.channel = ch;
    r.w.payload_byte = pb;
    r.w.control_byte = ctl;
    r.typed = typed;
    r.n = n[2:0];
    r.bytes = bytes;
    dir_tab.push_back(r);
  endtask

  // Stop sending, let every owed byte come out, then give the pipeline time
  // to finish words that owe nothing (empty end of message).
  task automatic drain_all();
    push <= 1'b0;
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic load_poly(input logic [15:0] p);
    cfg_write <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_write <= 1'b0;
    poly_q = p;
  endtask

  function automatic logic [15:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return last_chan;
    if (r < 70) return 16'h0000;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return FLAG_BYTE;
    if (r < 30) return ESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_control();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h00;
    if (r < 40) return CTL_BOT;
    if (r < 50) return CTL_BOTM;
    if (r < 60) return CTL_BOTS;
    if (r < 70) return FLAG_BYTE;
    if (r < 75) return ESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Nonzero control that is not one of the three frame-keeping codes.
  function automatic logic [7:0] closing_control();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CTL_BOT || c == CTL_BOTM || c == CTL_BOTS);
    return c;
  endfunction

  // A message on one channel: a few payload words and usually an end word.
  // One in ten is a stray word with every field random; some messages
  // are cut off without their end word.
  task automatic send_message();
    logic [15:0] ch;
    int          len;
    if ($urandom_range(0, 9) == 0) begin
      send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      ch = pick_channel();
      last_chan = ch;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) send_item(CMD_DATA, ch, pick_payload(), 8'h00);
      if ($urandom_range(0, 4) != 0) send_item(CMD_END, ch, pick_payload(), pick_control());
    end
  endtask

  // Keeps one frame open with escape-heavy traffic (two counted bytes per
  // word) and steers the last words so the full-frame close lands exactly
  // where the chosen corner case wants it.
  task automatic fill_frame(input fill_end_e how);
    logic [15:0] ch;
    logic [7:0]  pb;
    bit          done;
    int          r;
    ch = 16'($urandom_range(0, 65535));
    last_chan = ch;
    done = 1'b0;
    while (!done) begin
      if (fill_cnt >= FULL_COUNT - 4) begin
        if (how == SPLIT_AT_ESCAPE && fill_cnt == FULL_COUNT - 1) begin
          send_item(CMD_DATA, ch, ESC_BYTE, 8'h00);
          done = 1'b1;
        end else if (how == SPLIT_AT_CONTROL && fill_cnt == FULL_COUNT - 1) begin
          send_item(CMD_END, ch, pick_payload(), closing_control());
          done = 1'b1;
        end else if (how == CONTROL_AFTER_FULL && fill_cnt == FULL_COUNT - 2) begin
          send_item(CMD_END, ch, pick_payload(), closing_control());
          done = 1'b1;
        end else begin
          // single counted byte to walk up to the boundary
          do pb = 8'($urandom_range(0, 255)); while (pb == ESC_BYTE);
          send_item(CMD_DATA, ch, pb, 8'h00);
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          send_item(CMD_DATA, ch, ESC_BYTE, 8'h00);
        end else if (r < 9) begin
          send_item(CMD_DATA, ch, pick_payload(), 8'h00);
        end else begin
          case ($urandom_range(0, 2))
            0: send_item(CMD_END, ch, pick_payload(), CTL_BOT);
            1: send_item(CMD_END, ch, pick_payload(), CTL_BOTM);
            default: send_item(CMD_END, ch, pick_payload(), CTL_BOTS);
          endcase
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // Receiver side: random pop stalls, short mostly, a few long, with
  // calm stretches where every byte is taken at once.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm_rx <= !calm_rx;
    if (rx_hold != 0) begin
      pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      pop <= 1'b1;
      if (!calm_rx) begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 15) begin
          rx_hold <= $urandom_range(1, 3);
        end else if (rx_roll < 17) begin
          rx_hold <= $urandom_range(20, 50);
        end
      end
    end
  end

  // Result checker: each byte taken is compared with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (line_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected line byte %02h", result.line_byte));
      end else begin
        if (result.line_byte !== line_bytes_due[0].line_byte) begin
          flag_mismatch($sformatf("line_byte got %02h want %02h",
                                  result.line_byte, line_bytes_due[0].line_byte));
        end
        if (result.frame_end !== line_bytes_due[0].frame_end) begin
          flag_mismatch($sformatf("frame_end got %b want %b on byte %02h",
                                  result.frame_end, line_bytes_due[0].frame_end,
                                  line_bytes_due[0].line_byte));
        end
        if (result.last_of_run !== line_bytes_due[0].last_of_run) begin
          flag_mismatch($sformatf("last_of_run got %b want %b on byte %02h",
                                  result.last_of_run, line_bytes_due[0].last_of_run,
                                  line_bytes_due[0].line_byte));
        end
        void'(line_bytes_due.pop_front());
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    int          base;
    logic [15:0] poly;
    fill_end_e   how;

    poly_q = CRC_POLY_RESET;
    chan_q = '0;
    chan_seen = 1'b0;
    fill_cnt = 0;
    crc_q = '0;

    // Directed table. Frame on channel 0 first: header 80 80, then plain,
    // flag-stuffed and escaped payload, and the three frame-keeping controls.
    add_row(CMD_DATA, 16'h0000, 8'h00, 8'h00, 1'b1, 3, 32'h8080_0000);
    add_row(CMD_END,  16'h0000, 8'h00, 8'h00, 1'b1, 0, 32'h0);  // empty end: nothing
    add_row(CMD_DATA, 16'h0000, 8'hFF, 8'h00, 1'b1, 1, 32'hFF00_0000);
    add_row(CMD_DATA, 16'h0000, FLAG_BYTE, 8'h00, 1'b1, 2, 32'h7E00_0000);
    add_row(CMD_DATA, 16'h0000, ESC_BYTE, 8'h00, 1'b1, 2, 32'h9D00_0000);
    add_row(CMD_END,  16'h0000, 8'h00, CTL_BOT, 1'b1, 2, {ESC_BYTE, CTL_BOT, 16'h0});
    add_row(CMD_END,  16'h0000, 8'h00, CTL_BOTM, 1'b1, 2, {ESC_BYTE, CTL_BOTM, 16'h0});
    add_row(CMD_END,  16'h0000, 8'h00, CTL_BOTS, 1'b1, 2, {ESC_BYTE, CTL_BOTS, 16'h0});
    // flag as control byte: stuffed, then the frame closes with its CRC
    add_row(CMD_END,  16'h0000, 8'h00, FLAG_BYTE, 1'b0, 0, 32'h0);
    // fresh frame on the top channel: header FE FE
    add_row(CMD_DATA, 16'hFFFF, 8'h00, 8'h00, 1'b1, 3, 32'hFEFE_0000);
    add_row(CMD_END,  16'hFFFF, 8'h00, 8'hFF, 1'b0, 0, 32'h0);
    add_row(CMD_DATA, 16'h5555, ESC_BYTE, 8'h00, 1'b1, 4, 32'hAAAA_9D00);
    // channel change closes the open frame before the new byte
    add_row(CMD_DATA, 16'hAAAA, 8'h01, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_END,  16'hAAAA, 8'h00, 8'h00, 1'b1, 0, 32'h0);
    // empty end on a new channel still closes the open frame
    add_row(CMD_END,  16'h1234, 8'h00, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_DATA, 16'h1234, FLAG_BYTE, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_END,  16'h1234, 8'h00, 8'h01, 1'b0, 0, 32'h0);
    // closing control with no frame open: opens one just to close it
    add_row(CMD_END,  16'h1234, 8'h00, 8'h01, 1'b0, 0, 32'h0);
    add_row(CMD_DATA, 16'h8001, 8'h80, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_END,  16'h8001, 8'h00, ESC_BYTE, 1'b0, 0, 32'h0);
    add_row(CMD_DATA, 16'h7FFF, 8'hAA, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_DATA, 16'h7FFF, 8'h55, 8'h00, 1'b0, 0, 32'h0);
    add_row(CMD_END,  16'h7FFF, 8'h00, 8'hFF, 1'b0, 0, 32'h0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, int'(dir_tab[i].n),
                                   dir_tab[i].bytes);

    // Random phases, each under its own polynomial: both extremes, a random
    // one, and back to the reset value. The sender pauses until every owed
    // byte is out before each write. All but the first phase start with a
    // run that fills a frame to the brim.
    for (int ph = 0; ph < 4; ph++) begin
      drain_all();
      case (ph)
        0: poly = 16'h0000;
        1: poly = 16'hFFFF;
        2: poly = 16'($urandom_range(0, 65535));
        default: poly = CRC_POLY_RESET;
      endcase
      load_poly(poly);
      base = words_sent;
      if (ph > 0) begin
        case (ph)
          1: how = SPLIT_AT_ESCAPE;
          2: how = SPLIT_AT_CONTROL;
          default: how = CONTROL_AFTER_FULL;
        endcase
        fill_frame(how);
      end
      while (words_sent - base < PHASE_WORDS) send_message();
    end

    drain_all();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
